[rtl/aes_cfb_pkg.sv]
// shared types, constants and functions for the aes-128 cfb byte cipher
`default_nettype none
package aes_cfb_pkg;

  localparam int unsigned BlkBytes = 16;
  localparam int unsigned NumRounds = 10;

  typedef logic [7:0] byte_t;
  typedef logic [127:0] block_t;
  typedef logic [2:0] cfg_idx_t;

  localparam cfg_idx_t CfgKeyHigh = 3'd0;
  localparam cfg_idx_t CfgKeyLow = 3'd1;
  localparam cfg_idx_t CfgIvHigh = 3'd2;
  localparam cfg_idx_t CfgIvLow = 3'd3;
  localparam cfg_idx_t CfgDirection = 3'd4;

  localparam byte_t RconFirst = 8'h01;
  localparam byte_t GfPoly = 8'h1b;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ROUND,
    ST_OUT
  } state_t;

  function automatic byte_t sbox(input byte_t a);
    byte_t r;
    r = 8'h00;
    case (a)
      8'h00: r = 8'h63; 8'h01: r = 8'h7c; 8'h02: r = 8'h77; 8'h03: r = 8'h7b;
      8'h04: r = 8'hf2; 8'h05: r = 8'h6b; 8'h06: r = 8'h6f; 8'h07: r = 8'hc5;
      8'h08: r = 8'h30; 8'h09: r = 8'h01; 8'h0a: r = 8'h67; 8'h0b: r = 8'h2b;
      8'h0c: r = 8'hfe; 8'h0d: r = 8'hd7; 8'h0e: r = 8'hab; 8'h0f: r = 8'h76;
      8'h10: r = 8'hca; 8'h11: r = 8'h82; 8'h12: r = 8'hc9; 8'h13: r = 8'h7d;
      8'h14: r = 8'hfa; 8'h15: r = 8'h59; 8'h16: r = 8'h47; 8'h17: r = 8'hf0;
      8'h18: r = 8'had; 8'h19: r = 8'hd4; 8'h1a: r = 8'ha2; 8'h1b: r = 8'haf;
      8'h1c: r = 8'h9c; 8'h1d: r = 8'ha4; 8'h1e: r = 8'h72; 8'h1f: r = 8'hc0;
      8'h20: r = 8'hb7; 8'h21: r = 8'hfd; 8'h22: r = 8'h93; 8'h23: r = 8'h26;
      8'h24: r = 8'h36; 8'h25: r = 8'h3f; 8'h26: r = 8'hf7; 8'h27: r = 8'hcc;
      8'h28: r = 8'h34; 8'h29: r = 8'ha5; 8'h2a: r = 8'he5; 8'h2b: r = 8'hf1;
      8'h2c: r = 8'h71; 8'h2d: r = 8'hd8; 8'h2e: r = 8'h31; 8'h2f: r = 8'h15;
      8'h30: r = 8'h04; 8'h31: r = 8'hc7; 8'h32: r = 8'h23; 8'h33: r = 8'hc3;
      8'h34: r = 8'h18; 8'h35: r = 8'h96; 8'h36: r = 8'h05; 8'h37: r = 8'h9a;
      8'h38: r = 8'h07; 8'h39: r = 8'h12; 8'h3a: r = 8'h80; 8'h3b: r = 8'he2;
      8'h3c: r = 8'heb; 8'h3d: r = 8'h27; 8'h3e: r = 8'hb2; 8'h3f: r = 8'h75;
      8'h40: r = 8'h09; 8'h41: r = 8'h83; 8'h42: r = 8'h2c; 8'h43: r = 8'h1a;
      8'h44: r = 8'h1b; 8'h45: r = 8'h6e; 8'h46: r = 8'h5a; 8'h47: r = 8'ha0;
      8'h48: r = 8'h52; 8'h49: r = 8'h3b; 8'h4a: r = 8'hd6; 8'h4b: r = 8'hb3;
      8'h4c: r = 8'h29; 8'h4d: r = 8'he3; 8'h4e: r = 8'h2f; 8'h4f: r = 8'h84;
      8'h50: r = 8'h53; 8'h51: r = 8'hd1; 8'h52: r = 8'h00; 8'h53: r = 8'hed;
      8'h54: r = 8'h20; 8'h55: r = 8'hfc; 8'h56: r = 8'hb1; 8'h57: r = 8'h5b;
      8'h58: r = 8'h6a; 8'h59: r = 8'hcb; 8'h5a: r = 8'hbe; 8'h5b: r = 8'h39;
      8'h5c: r = 8'h4a; 8'h5d: r = 8'h4c; 8'h5e: r = 8'h58; 8'h5f: r = 8'hcf;
      8'h60: r = 8'hd0; 8'h61: r = 8'hef; 8'h62: r = 8'haa; 8'h63: r = 8'hfb;
      8'h64: r = 8'h43; 8'h65: r = 8'h4d; 8'h66: r = 8'h33; 8'h67: r = 8'h85;
      8'h68: r = 8'h45; 8'h69: r = 8'hf9; 8'h6a: r = 8'h02; 8'h6b: r = 8'h7f;
      8'h6c: r = 8'h50; 8'h6d: r = 8'h3c; 8'h6e: r = 8'h9f; 8'h6f: r = 8'ha8;
      8'h70: r = 8'h51; 8'h71: r = 8'ha3; 8'h72: r = 8'h40; 8'h73: r = 8'h8f;
      8'h74: r = 8'h92; 8'h75: r = 8'h9d; 8'h76: r = 8'h38; 8'h77: r = 8'hf5;
      8'h78: r = 8'hbc; 8'h79: r = 8'hb6; 8'h7a: r = 8'hda; 8'h7b: r = 8'h21;
      8'h7c: r = 8'h10; 8'h7d: r = 8'hff; 8'h7e: r = 8'hf3; 8'h7f: r = 8'hd2;
      8'h80: r = 8'hcd; 8'h81: r = 8'h0c; 8'h82: r = 8'h13; 8'h83: r = 8'hec;
      8'h84: r = 8'h5f; 8'h85: r = 8'h97; 8'h86: r = 8'h44; 8'h87: r = 8'h17;
      8'h88: r = 8'hc4; 8'h89: r = 8'ha7; 8'h8a: r = 8'h7e; 8'h8b: r = 8'h3d;
      8'h8c: r = 8'h64; 8'h8d: r = 8'h5d; 8'h8e: r = 8'h19; 8'h8f: r = 8'h73;
      8'h90: r = 8'h60; 8'h91: r = 8'h81; 8'h92: r = 8'h4f; 8'h93: r = 8'hdc;
      8'h94: r = 8'h22; 8'h95: r = 8'h2a; 8'h96: r = 8'h90; 8'h97: r = 8'h88;
      8'h98: r = 8'h46; 8'h99: r = 8'hee; 8'h9a: r = 8'hb8; 8'h9b: r = 8'h14;
      8'h9c: r = 8'hde; 8'h9d: r = 8'h5e; 8'h9e: r = 8'h0b; 8'h9f: r = 8'hdb;
      8'ha0: r = 8'he0; 8'ha1: r = 8'h32; 8'ha2: r = 8'h3a; 8'ha3: r = 8'h0a;
      8'ha4: r = 8'h49; 8'ha5: r = 8'h06; 8'ha6: r = 8'h24; 8'ha7: r = 8'h5c;
      8'ha8: r = 8'hc2; 8'ha9: r = 8'hd3; 8'haa: r = 8'hac; 8'hab: r = 8'h62;
      8'hac: r = 8'h91; 8'had: r = 8'h95; 8'hae: r = 8'he4; 8'haf: r = 8'h79;
      8'hb0: r = 8'he7; 8'hb1: r = 8'hc8; 8'hb2: r = 8'h37; 8'hb3: r = 8'h6d;
      8'hb4: r = 8'h8d; 8'hb5: r = 8'hd5; 8'hb6: r = 8'h4e; 8'hb7: r = 8'ha9;
      8'hb8: r = 8'h6c; 8'hb9: r = 8'h56; 8'hba: r = 8'hf4; 8'hbb: r = 8'hea;
      8'hbc: r = 8'h65; 8'hbd: r = 8'h7a; 8'hbe: r = 8'hae; 8'hbf: r = 8'h08;
      8'hc0: r = 8'hba; 8'hc1: r = 8'h78; 8'hc2: r = 8'h25; 8'hc3: r = 8'h2e;
      8'hc4: r = 8'h1c; 8'hc5: r = 8'ha6; 8'hc6: r = 8'hb4; 8'hc7: r = 8'hc6;
      8'hc8: r = 8'he8; 8'hc9: r = 8'hdd; 8'hca: r = 8'h74; 8'hcb: r = 8'h1f;
      8'hcc: r = 8'h4b; 8'hcd: r = 8'hbd; 8'hce: r = 8'h8b; 8'hcf: r = 8'h8a;
      8'hd0: r = 8'h70; 8'hd1: r = 8'h3e; 8'hd2: r = 8'hb5; 8'hd3: r = 8'h66;
      8'hd4: r = 8'h48; 8'hd5: r = 8'h03; 8'hd6: r = 8'hf6; 8'hd7: r = 8'h0e;
      8'hd8: r = 8'h61; 8'hd9: r = 8'h35; 8'hda: r = 8'h57; 8'hdb: r = 8'hb9;
      8'hdc: r = 8'h86; 8'hdd: r = 8'hc1; 8'hde: r = 8'h1d; 8'hdf: r = 8'h9e;
      8'he0: r = 8'he1; 8'he1: r = 8'hf8; 8'he2: r = 8'h98; 8'he3: r = 8'h11;
      8'he4: r = 8'h69; 8'he5: r = 8'hd9; 8'he6: r = 8'h8e; 8'he7: r = 8'h94;
      8'he8: r = 8'h9b; 8'he9: r = 8'h1e; 8'hea: r = 8'h87; 8'heb: r = 8'he9;
      8'hec: r = 8'hce; 8'hed: r = 8'h55; 8'hee: r = 8'h28; 8'hef: r = 8'hdf;
      8'hf0: r = 8'h8c; 8'hf1: r = 8'ha1; 8'hf2: r = 8'h89; 8'hf3: r = 8'h0d;
      8'hf4: r = 8'hbf; 8'hf5: r = 8'he6; 8'hf6: r = 8'h42; 8'hf7: r = 8'h68;
      8'hf8: r = 8'h41; 8'hf9: r = 8'h99; 8'hfa: r = 8'h2d; 8'hfb: r = 8'h0f;
      8'hfc: r = 8'hb0; 8'hfd: r = 8'h54; 8'hfe: r = 8'hbb; 8'hff: r = 8'h16;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  function automatic byte_t gf_dbl(input byte_t v);
    return {v[6:0], 1'b0} ^ (v[7] ? GfPoly : 8'h00);
  endfunction

  // byte i of a block sits at bits [127-8i -: 8]
  function automatic byte_t blk_byte(input block_t b, input int unsigned i);
    return b[127 - 8 * i -: 8];
  endfunction

  function automatic block_t sub_shift(input block_t s);
    block_t t;
    t = '0;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        t[127 - 8 * (r + 4 * c) -: 8] = sbox(blk_byte(s, r + 4 * ((c + r) % 4)));
      end
    end
    return t;
  endfunction

  function automatic block_t mix(input block_t s);
    block_t t;
    byte_t a0, a1, a2, a3, all;
    t = '0;
    for (int c = 0; c < 4; c++) begin
      a0 = blk_byte(s, 4 * c);
      a1 = blk_byte(s, 4 * c + 1);
      a2 = blk_byte(s, 4 * c + 2);
      a3 = blk_byte(s, 4 * c + 3);
      all = a0 ^ a1 ^ a2 ^ a3;
      t[127 - 32 * c -: 8] = a0 ^ all ^ gf_dbl(a0 ^ a1);
      t[119 - 32 * c -: 8] = a1 ^ all ^ gf_dbl(a1 ^ a2);
      t[111 - 32 * c -: 8] = a2 ^ all ^ gf_dbl(a2 ^ a3);
      t[103 - 32 * c -: 8] = a3 ^ all ^ gf_dbl(a3 ^ a0);
    end
    return t;
  endfunction

  // next round key from the current one
  function automatic block_t key_next(input block_t k, input byte_t rc);
    logic [31:0] w0, w1, w2, w3, t;
    w0 = k[127:96];
    w1 = k[95:64];
    w2 = k[63:32];
    w3 = k[31:0];
    t = {sbox(w3[23:16]), sbox(w3[15:8]), sbox(w3[7:0]), sbox(w3[31:24])}
      ^ {rc, 24'h000000};
    w0 = w0 ^ t;
    w1 = w1 ^ w0;
    w2 = w2 ^ w1;
    w3 = w3 ^ w2;
    return {w0, w1, w2, w3};
  endfunction

endpackage
`default_nettype wire

[rtl/aes128_cfb_byte_stream_cipher.sv]
// top level: byte-wise aes-128 cfb-128 cipher with an iterative round unit
//
// channel   signals                                 direction
// cfg       cfg_valid cfg_ready cfg_index cfg_data  in
// input     in_valid in_ready data_byte restart     in
// output    out_valid out_ready out_byte            out
//
// a byte with a keystream block in hand goes from accept straight to its result
// a byte that opens a new block first runs every aes round in turn in the
// shared round unit with on-the-fly key schedule
// reset loads a zero key and iv and forces a new block on the first byte
// the input waits while a result is held; cfg is ready only when idle with no byte offered
`default_nettype none
module aes128_cfb_byte_stream_cipher (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          cfg_valid,
  output logic                         cfg_ready,
  input  wire  aes_cfb_pkg::cfg_idx_t  cfg_index,
  input  wire  [63:0]                  cfg_data,
  input  wire                          in_valid,
  output logic                         in_ready,
  input  wire  [7:0]                   data_byte,
  input  wire                          restart,
  output logic                         out_valid,
  input  wire                          out_ready,
  output logic [7:0]                   out_byte
);
  import aes_cfb_pkg::*;

  block_t key, iv, feedback, keystream, state, rkey;
  logic direction;
  logic [4:0] offset;
  logic [3:0] round;
  byte_t rcon, din, res;
  state_t st, st_next;
  logic cfg_we, reinit, in_acc, need_blk;
  block_t fb_src;
  logic [3:0] pos;

  assign cfg_ready = (st == ST_IDLE) && !in_valid;
  assign cfg_we = cfg_valid && cfg_ready;
  assign reinit = cfg_we && (cfg_index == CfgKeyHigh || cfg_index == CfgKeyLow ||
                             cfg_index == CfgIvHigh || cfg_index == CfgIvLow);
  assign in_acc = in_valid && in_ready;
  assign in_ready = (st == ST_IDLE);
  assign out_valid = (st == ST_OUT);
  assign fb_src = restart ? iv : feedback;
  assign need_blk = restart || offset[4];
  assign pos = offset[3:0];

  always_comb begin
    st_next = st;
    unique case (st)
      ST_IDLE: if (in_acc) st_next = need_blk ? ST_ROUND : ST_OUT;
      ST_ROUND: if (round == 4'(NumRounds)) st_next = ST_OUT;
      ST_OUT: if (out_ready) st_next = ST_IDLE;
      default: st_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= ST_IDLE;
    end else begin
      st <= st_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      key <= '0;
      iv <= '0;
      feedback <= '0;
      keystream <= '0;
      direction <= 1'b0;
      offset <= 5'(BlkBytes);
      round <= '0;
      rcon <= RconFirst;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CfgKeyHigh: key[127:64] <= cfg_data;
          CfgKeyLow: key[63:0] <= cfg_data;
          CfgIvHigh: iv[127:64] <= cfg_data;
          CfgIvLow: iv[63:0] <= cfg_data;
          CfgDirection: direction <= cfg_data[0];
          default: ;
        endcase
      end
      if (reinit) begin
        offset <= 5'(BlkBytes);
        keystream <= '0;
        unique case (cfg_index)
          CfgIvHigh: feedback <= {cfg_data, iv[63:0]};
          CfgIvLow: feedback <= {iv[127:64], cfg_data};
          default: feedback <= iv;
        endcase
      end
      unique case (st)
        ST_IDLE: if (in_acc) begin
          din <= data_byte;
          if (need_blk) begin
            feedback <= fb_src;
            state <= fb_src ^ key;
            rkey <= key_next(key, RconFirst);
            rcon <= gf_dbl(RconFirst);
            round <= 4'd1;
            offset <= '0;
          end
        end
        ST_ROUND: begin
          if (round == 4'(NumRounds)) begin
            keystream <= sub_shift(state) ^ rkey;
          end else begin
            state <= mix(sub_shift(state)) ^ rkey;
            rkey <= key_next(rkey, rcon);
            rcon <= gf_dbl(rcon);
          end
          round <= round + 4'd1;
        end
        ST_OUT: if (out_ready) begin
          feedback[127 - 8 * pos -: 8] <= direction ? din : res;
          offset <= {1'b0, pos} + 5'd1;
        end
        default: ;
      endcase
    end
  end

  assign res = din ^ keystream[127 - 8 * pos -: 8];
  assign out_byte = res;

endmodule
`default_nettype wire

[verif/aes128_cfb_byte_stream_cipher_chk.sv]
// checker: watches the three channels, predicts each output byte and compares
`timescale 1ns / 100ps
`default_nettype none
module aes128_cfb_byte_stream_cipher_chk (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          cfg_valid,
  input  wire                          cfg_ready,
  input  wire  aes_cfb_pkg::cfg_idx_t  cfg_index,
  input  wire  [63:0]                  cfg_data,
  input  wire                          in_valid,
  input  wire                          in_ready,
  input  wire  [7:0]                   data_byte,
  input  wire                          restart,
  input  wire                          out_valid,
  input  wire                          out_ready,
  input  wire  [7:0]                   out_byte,
  output int                           errors,
  output int                           pending
);
  import aes_cfb_pkg::*;

  logic [7:0]  subst [256];
  logic [63:0] key_hi, key_lo, iv_hi, iv_lo;
  logic        decrypt;
  logic [7:0]  feedback [16];
  logic [7:0]  keystream [16];
  logic [4:0]  offset;
  logic [31:0] rkey [44];
  logic [7:0]  expected_bytes [$];

  function automatic logic [7:0] xtime(input logic [7:0] v);
    return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] gmul(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] p;
    p = 8'h00;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) p = p ^ a;
      a = xtime(a);
    end
    return p;
  endfunction

  function automatic logic [7:0] rotl(input logic [7:0] v, input int n);
    return (v << n) | (v >> (8 - n));
  endfunction

  // s-box from the field inverse and the affine map
  initial begin
    logic [7:0] inv;
    for (int a = 0; a < 256; a++) begin
      inv = 8'h01;
      if (a == 0) inv = 8'h00;
      else for (int k = 0; k < 254; k++) inv = gmul(inv, a[7:0]);
      subst[a] = inv ^ rotl(inv, 1) ^ rotl(inv, 2) ^ rotl(inv, 3) ^ rotl(inv, 4) ^ 8'h63;
    end
  end

  function automatic void reload_iv();
    for (int i = 0; i < 8; i++) begin
      feedback[i] = iv_hi[63 - 8 * i -: 8];
      feedback[8 + i] = iv_lo[63 - 8 * i -: 8];
    end
  endfunction

  function automatic void fresh_start();
    logic [7:0]  rc;
    logic [31:0] t;
    rc = RconFirst;
    rkey[0] = key_hi[63:32];
    rkey[1] = key_hi[31:0];
    rkey[2] = key_lo[63:32];
    rkey[3] = key_lo[31:0];
    for (int i = 4; i < 44; i++) begin
      t = rkey[i - 1];
      if (i % 4 == 0) begin
        t = {subst[t[23:16]], subst[t[15:8]], subst[t[7:0]], subst[t[31:24]]}
          ^ {rc, 24'h0};
        rc = xtime(rc);
      end
      rkey[i] = rkey[i - 4] ^ t;
    end
    reload_iv();
    for (int i = 0; i < 16; i++) keystream[i] = 8'h00;
    offset = 5'd16;
  endfunction

  function automatic void encrypt_feedback();
    logic [7:0] s [16];
    logic [7:0] t [16];
    logic [7:0] a0, a1, a2, a3, all;
    for (int i = 0; i < 16; i++) s[i] = feedback[i] ^ rkey[i / 4][31 - 8 * (i % 4) -: 8];
    for (int rnd = 1; rnd <= 10; rnd++) begin
      for (int c = 0; c < 4; c++)
        for (int r = 0; r < 4; r++)
          t[r + 4 * c] = subst[s[r + 4 * ((c + r) % 4)]];
      for (int c = 0; c < 4; c++) begin
        a0 = t[4 * c]; a1 = t[4 * c + 1]; a2 = t[4 * c + 2]; a3 = t[4 * c + 3];
        all = a0 ^ a1 ^ a2 ^ a3;
        if (rnd < 10) begin
          t[4 * c]     = a0 ^ all ^ xtime(a0 ^ a1);
          t[4 * c + 1] = a1 ^ all ^ xtime(a1 ^ a2);
          t[4 * c + 2] = a2 ^ all ^ xtime(a2 ^ a3);
          t[4 * c + 3] = a3 ^ all ^ xtime(a3 ^ a0);
        end
      end
      for (int i = 0; i < 16; i++) s[i] = t[i] ^ rkey[4 * rnd + i / 4][31 - 8 * (i % 4) -: 8];
    end
    for (int i = 0; i < 16; i++) keystream[i] = s[i];
  endfunction

  function automatic logic [7:0] predict_byte(input logic [7:0] din, input logic rs);
    logic [7:0] res;
    logic [3:0] pos;
    if (rs) begin
      reload_iv();
      offset = 5'd16;
    end
    if (offset >= 5'd16) begin
      encrypt_feedback();
      offset = 5'd0;
    end
    pos = offset[3:0];
    res = din ^ keystream[pos];
    feedback[pos] = decrypt ? din : res;
    offset = {1'b0, pos} + 5'd1;
    return res;
  endfunction

  task automatic report(input string what, input logic [7:0] got, input logic [7:0] want);
    $display("%0t mismatch: %s got %02h want %02h", $realtime, what, got, want);
    errors++;
  endtask

  always @(posedge clk) begin
    logic [7:0] want;
    if (rst) begin
      key_hi = '0; key_lo = '0; iv_hi = '0; iv_lo = '0; decrypt = 1'b0;
      fresh_start();
      expected_bytes.delete();
      errors = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_bytes.size() == 0) report("unexpected out_byte", out_byte, 8'h00);
        else begin
          want = expected_bytes.pop_front();
          if (out_byte !== want) report("out_byte", out_byte, want);
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CfgKeyHigh:   begin key_hi = cfg_data; fresh_start(); end
          CfgKeyLow:    begin key_lo = cfg_data; fresh_start(); end
          CfgIvHigh:    begin iv_hi = cfg_data; fresh_start(); end
          CfgIvLow:     begin iv_lo = cfg_data; fresh_start(); end
          CfgDirection: decrypt = cfg_data[0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) expected_bytes.push_back(predict_byte(data_byte, restart));
    end
    pending <= expected_bytes.size();
  end
endmodule
`default_nettype wire

[verif/aes128_cfb_byte_stream_cipher_tb.sv]
// testbench top: drives config and byte requests, gives the verdict
`timescale 1ns / 100ps
`default_nettype none
module aes128_cfb_byte_stream_cipher_tb;
  import aes_cfb_pkg::*;

  localparam cfg_idx_t CfgUnused = 3'd7;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  cfg_idx_t   cfg_index = CfgKeyHigh;
  logic [63:0] cfg_data = '0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] data_byte = '0;
  logic       restart = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] out_byte;
  int         errors;
  int         pending;
  logic       no_gaps = 1'b0;
  int         sent = 0;
  int         stall_left = 0;

  always #5 clk = ~clk;

  aes128_cfb_byte_stream_cipher uut (
    .clk, .rst, .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
    .in_valid, .in_ready, .data_byte, .restart,
    .out_valid, .out_ready, .out_byte
  );

  aes128_cfb_byte_stream_cipher_chk chk (
    .clk, .rst, .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
    .in_valid, .in_ready, .data_byte, .restart,
    .out_valid, .out_ready, .out_byte, .errors, .pending
  );

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [63:0] pick_word();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // receiver stalls
  always @(posedge clk) begin
    if (rst) out_ready <= 1'b0;
    else if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      out_ready <= 1'b1;
      stall_left <= pick_gap();
    end
  end

  task automatic write_reg(input cfg_idx_t idx, input logic [63:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_byte(input logic [7:0] d, input logic rs);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    data_byte <= d;
    restart <= rs;
    do @(posedge clk); while (!in_ready);
    sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (20) @(posedge clk);
  endtask

  task automatic setup(input logic [63:0] kh, input logic [63:0] kl, input logic [63:0] ih,
                       input logic [63:0] il, input logic dir);
    write_reg(CfgKeyHigh, kh);
    write_reg(CfgKeyLow, kl);
    write_reg(CfgIvHigh, ih);
    write_reg(CfgIvLow, il);
    write_reg(CfgDirection, {63'h0, dir});
  endtask

  initial begin
    int n;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset key and iv, crossing a block edge, restart mid block
    send_byte(8'h00, 1'b0);
    send_byte(8'hff, 1'b0);
    for (int i = 0; i < 15; i++) send_byte(8'h01 << (i % 8), 1'b0);
    send_byte(8'h80, 1'b1);
    send_byte(8'h7f, 1'b0);
    drain();

    // all-ones key and iv, decrypt, plus an ignored index and a bare direction flip
    setup('1, '1, '1, '1, 1'b1);
    write_reg(CfgUnused, '1);
    send_byte(8'hff, 1'b1);
    send_byte(8'h00, 1'b0);
    send_byte(8'h5a, 1'b0);
    drain();
    write_reg(CfgDirection, 64'h0);
    send_byte(8'ha5, 1'b0);
    send_byte(8'h3c, 1'b1);
    drain();

    while (sent < 450) begin
      if ($urandom_range(0, 4) == 0) write_reg(CfgDirection, {$urandom, $urandom});
      else setup(pick_word(), pick_word(), pick_word(), pick_word(),
                 1'($urandom_range(0, 1)));
      no_gaps = ($urandom_range(0, 3) == 0);
      n = $urandom_range(10, 60);
      for (int i = 0; i < n; i++)
        send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 11) == 0);
      no_gaps = 1'b0;
      drain();
    end

    if (errors == 0) begin
      $display("aes128_cfb_byte_stream_cipher_tb: clean");
    end else begin
      $display("aes128_cfb_byte_stream_cipher_tb: errors");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("aes128_cfb_byte_stream_cipher_tb: errors");
    $finish;
  end
endmodule
`default_nettype wire
